// File: sv/ctf_pkg.sv
package ctf_pkg;

	localparam int TABLE_FRAC = 24;
	localparam int TABLE_LEN  = 24;
	localparam int PRESCALE   = 12;

	typedef enum logic [1:0] {
		REG_BIAS_X = 2'd0,
		REG_BIAS_Y = 2'd1,
		REG_BIAS_Z = 2'd2,
		REG_BLEND  = 2'd3
	} reg_idx_t;

	// atan(2^-i) in degrees, Q24
	function automatic logic signed [31:0] atan_entry(input logic [4:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0:  r = 32'sd754974720;
			5'd1:  r = 32'sd445687602;
			5'd2:  r = 32'sd235489088;
			5'd3:  r = 32'sd119537938;
			5'd4:  r = 32'sd60000934;
			5'd5:  r = 32'sd30029717;
			5'd6:  r = 32'sd15018523;
			5'd7:  r = 32'sd7509720;
			5'd8:  r = 32'sd3754917;
			5'd9:  r = 32'sd1877466;
			5'd10: r = 32'sd938734;
			5'd11: r = 32'sd469367;
			5'd12: r = 32'sd234684;
			5'd13: r = 32'sd117342;
			5'd14: r = 32'sd58671;
			5'd15: r = 32'sd29335;
			5'd16: r = 32'sd14668;
			5'd17: r = 32'sd7334;
			5'd18: r = 32'sd3667;
			5'd19: r = 32'sd1833;
			5'd20: r = 32'sd917;
			5'd21: r = 32'sd458;
			5'd22: r = 32'sd229;
			5'd23: r = 32'sd115;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} unit_ctl_t;

endpackage

// File: sv/ctf_sqrt.sv
// floor square root of a 58-bit value, one result bit per cycle
module ctf_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [57:0] radicand,
	output logic        done,
	output logic [28:0] root
);
	logic [57:0] rem_q;
	logic [28:0] root_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [31:0] trial;
	logic [31:0] top;

	assign top   = {rem_q[57:56], 30'(0)} | 32'(0);
	assign trial = {1'b0, root_q, 2'b01};

	logic [31:0] cur;
	logic [57:0] rem_sh;
	assign rem_sh = {rem_q[55:0], 2'b00};
	assign cur    = 32'(rem_q[57:56]);

	// restoring method: partial remainder kept separately
	logic [31:0] part_q;
	logic [31:0] part_n;
	assign part_n = {part_q[29:0], rem_q[57:56]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= radicand;
				root_q <= '0;
				part_q <= '0;
			end else if (busy_q) begin
				rem_q <= rem_sh;
				if (part_n >= trial) begin
					part_q <= part_n - trial;
					root_q <= {root_q[27:0], 1'b1};
				end else begin
					part_q <= part_n;
					root_q <= {root_q[27:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd28) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign root = root_q;

	logic unused;
	assign unused = ^{top, cur};
endmodule

// File: sv/ctf_cordic.sv
// CORDIC vectoring, one iteration per cycle
module ctf_cordic #(
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int CORDIC_STEPS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [29:0] x_in,
	input  logic signed [29:0] y_in,
	output logic               done,
	output logic signed [31:0] angle
);
	localparam int NSTEP = (CORDIC_STEPS < ctf_pkg::TABLE_LEN) ? CORDIC_STEPS
		: ctf_pkg::TABLE_LEN;
	localparam int SH = ctf_pkg::TABLE_FRAC - ANGLE_FRAC_BITS;

	logic signed [33:0] x_q, y_q;
	logic signed [33:0] z_q;
	logic [4:0]         i_q;
	logic               busy_q;
	logic signed [33:0] dx, dy, zr;
	logic               zero_q;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign zr = z_q + (34'sd1 <<< (SH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				x_q    <= 34'(x_in);
				y_q    <= 34'(y_in);
				z_q    <= '0;
				i_q    <= '0;
				zero_q <= (y_in == '0);
			end else if (busy_q) begin
				if (y_q > 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + 34'(ctf_pkg::atan_entry(i_q));
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - 34'(ctf_pkg::atan_entry(i_q));
				end
				i_q <= i_q + 5'd1;
				if (32'(i_q) == NSTEP - 1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	logic signed [33:0] zs;
	assign zs    = zr >>> SH;
	assign angle = zero_q ? 32'sd0 : zs[31:0];
endmodule

// File: sv/complementary_tilt_filter.sv
// channel | direction | signals
// in      | input     | in_valid in_ready accel_x accel_y accel_z rate_x rate_z elapsed_us
// out     | output    | out_valid out_ready pitch_deg yaw_deg
// cfg     | input     | cfg_we cfg_index cfg_data
// A transaction produces the pitch and then the yaw angle. Per angle: squares,
// bit-serial root, CORDIC iterations, the gyro quotient and 2 blend steps.
// The square root and CORDIC units are shared by the pitch and yaw angles.
// in_ready is low while a transaction is in work or its result waits on out_ready.
// Reset clears the estimates and loads the default registers.
module complementary_tilt_filter #(
	parameter int ANGLE_FRAC_BITS = 16,
	parameter int CORDIC_STEPS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] rate_x,
	input  logic signed [15:0] rate_z,
	input  logic [19:0]        elapsed_us,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pitch_deg,
	output logic signed [31:0] yaw_deg,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	typedef enum logic [3:0] {
		IDLE, SQ_GO, SQ_WAIT, CO_GO, CO_WAIT, QEST, QREM, QFIX, INC, BLEND, NEXT, OUT
	} state_t;

	state_t             state_q;
	logic               sel_q;   // 0 pitch, 1 yaw
	logic signed [15:0] bx_q, by_q, bz_q;
	logic [15:0]        w_q;
	logic signed [31:0] pest_q, yest_q;
	logic signed [16:0] cx_q, cy_q, cz_q;
	logic signed [15:0] rx_q, rz_q;
	logic [19:0]        us_q;
	logic signed [31:0] tilt_q;
	logic [28:0]        root_q;
	logic signed [63:0] inc_q;

	// operand selection for the current angle
	logic signed [16:0] num, oa, ob;
	logic [33:0]        sq;
	logic [57:0]        rad;
	assign num = sel_q ? cz_q : -cx_q;
	assign oa  = sel_q ? cx_q : cy_q;
	assign ob  = sel_q ? cy_q : cz_q;
	logic [33:0] sqa_q, sqb_q;
	assign sq  = sqa_q + sqb_q;
	assign rad = {sq[33:0], 24'd0};

	logic        sq_start, sq_done, co_start, co_done;
	logic [28:0] sq_root;
	logic signed [31:0] co_angle;
	assign sq_start = (state_q == SQ_GO);
	assign co_start = (state_q == CO_GO);

	ctf_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(rad),
		.done(sq_done), .root(sq_root)
	);

	ctf_cordic #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(co_start),
		.x_in({1'b0, root_q}), .y_in(30'(num) <<< ctf_pkg::PRESCALE),
		.done(co_done), .angle(co_angle)
	);

	// gyro increment: (|rate|*us<<F + 8e6) / 16e6 = ((...) >> 10) / 15625;
	// quotient estimated by reciprocal multiply, then corrected by compare and subtract
	localparam int DW = 36 + ANGLE_FRAC_BITS + 1;
	localparam int GW = DW - 10;
	localparam logic [31:0] RECIP   = 32'd2251799813;  // floor(2^45 / 15625)
	localparam logic [19:0] DIV_ODD = 20'd15625;
	logic [GW-1:0] gb_q;
	logic [31:0]   qe_q;
	logic [19:0]   grem_q;
	logic          neg_q;
	logic signed [15:0] rsel;
	logic [15:0]   rmag;
	logic [35:0]   prod;
	logic [DW-1:0] gnum;
	logic [63:0]   qprod;
	assign rsel  = sel_q ? rz_q : rx_q;
	assign rmag  = rsel[15] ? 16'(-rsel) : 16'(rsel);
	assign prod  = 36'(rmag) * 36'(us_q);
	assign gnum  = DW'({prod, ANGLE_FRAC_BITS'(0)}) + DW'(64'd8000000);
	assign qprod = 64'(32'(gb_q >> 14)) * 64'(RECIP);

	// blend
	logic signed [31:0] est;
	logic signed [63:0] sum, acc, accs;
	logic signed [63:0] mula_q, mulb_q;
	assign est  = sel_q ? yest_q : pest_q;
	assign sum  = 64'(est) + inc_q;
	assign acc  = mula_q + mulb_q + 64'sd32768;
	assign accs = acc >>> 16;
	logic signed [31:0] sat;
	always_comb begin
		if (accs > 64'sd2147483647) sat = 32'h7fffffff;
		else if (accs < -64'sd2147483648) sat = 32'h80000000;
		else sat = accs[31:0];
	end

	logic [1:0] bstep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			out_valid <= 1'b0;
			bx_q      <= '0;
			by_q      <= '0;
			bz_q      <= '0;
			w_q       <= 16'd62915;
			pest_q    <= '0;
			yest_q    <= '0;
			sel_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ctf_pkg::REG_BIAS_X: bx_q <= cfg_data;
					ctf_pkg::REG_BIAS_Y: by_q <= cfg_data;
					ctf_pkg::REG_BIAS_Z: bz_q <= cfg_data;
					ctf_pkg::REG_BLEND:  w_q  <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				IDLE: if (in_valid) begin
					cx_q  <= 17'(accel_x) - 17'(bx_q);
					cy_q  <= 17'(accel_y) - 17'(by_q);
					cz_q  <= 17'(accel_z) - 17'(bz_q);
					rx_q  <= rate_x;
					rz_q  <= rate_z;
					us_q  <= elapsed_us;
					sel_q <= 1'b0;
					bstep_q <= '0;
					state_q <= NEXT;
				end
				NEXT: begin
					sqa_q   <= 34'(oa * oa);
					sqb_q   <= 34'(ob * ob);
					state_q <= SQ_GO;
				end
				SQ_GO: state_q <= SQ_WAIT;
				SQ_WAIT: if (sq_done) begin
					root_q  <= sq_root;
					state_q <= CO_GO;
				end
				CO_GO: state_q <= CO_WAIT;
				CO_WAIT: if (co_done) begin
					tilt_q  <= co_angle;
					neg_q   <= rsel[15];
					gb_q    <= GW'(gnum >> 10);
					state_q <= QEST;
				end
				QEST: begin
					qe_q    <= qprod[62:31];
					state_q <= QREM;
				end
				QREM: begin
					grem_q  <= 20'(gb_q) - 20'(qe_q[19:0] * DIV_ODD);
					state_q <= QFIX;
				end
				QFIX: if (grem_q >= DIV_ODD) begin
					grem_q <= grem_q - DIV_ODD;
					qe_q   <= qe_q + 32'd1;
				end else begin
					state_q <= INC;
				end
				INC: begin
					inc_q   <= neg_q ? -64'(qe_q) : 64'(qe_q);
					state_q <= BLEND;
				end
				BLEND: begin
					if (bstep_q == 2'd0) begin
						bstep_q <= 2'd1;
						mula_q <= $signed({48'd0, w_q}) * sum;
						mulb_q <= (64'sd65536 - $signed({48'd0, w_q})) * 64'(tilt_q);
					end else begin
						bstep_q <= '0;
						if (sel_q) begin
							yest_q    <= sat;
							out_valid <= 1'b1;
							state_q   <= OUT;
						end else begin
							pest_q  <= sat;
							sel_q   <= 1'b1;
							state_q <= NEXT;
						end
					end
				end
				OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q   <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == IDLE);
	assign pitch_deg = pest_q;
	assign yaw_deg   = yest_q;

`ifndef NO_ASSERTIONS
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("ready while result pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pitch_deg) && $stable(yaw_deg))
		else $error("result changed while stalled");
	a_sq_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		sq_start |=> !sq_done) else $error("root done too early");
`endif
endmodule
